// ===== hdl/sfrx_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfrx_pkg
// Shared types, constants and the CRC step for the byte-stuffed frame receiver.
// ----------------------------------------------------------------------------
package sfrx_pkg;

    localparam int unsigned COUNT_WIDTH_DEFAULT = 16;
    localparam int unsigned QUEUE_ADDR_WIDTH    = 2;
    localparam int unsigned CFG_INDEX_WIDTH     = 1;

    localparam logic [15:0] CRC_POLY = 16'h8408;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_GOOD = 16'hF0B8;

    localparam logic [7:0] FLAG_OPEN  = 8'hC0;
    localparam logic [7:0] FLAG_CLOSE = 8'hC1;
    localparam logic [7:0] ESC_BYTE   = 8'h7D;
    localparam logic [7:0] ESC_XOR    = 8'h20;

    localparam logic [7:0] PROTOCOL_ID_RESET  = 8'h11;
    localparam logic [7:0] MESSAGE_TYPE_RESET = 8'h01;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PROTOCOL_ID  = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MESSAGE_TYPE = CFG_INDEX_WIDTH'(1);

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_OPEN  = 2'd1,
        KIND_CLOSE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_GOOD       = 2'd0,
        ST_BAD_FCS    = 2'd1,
        ST_BAD_HEADER = 2'd2,
        ST_SHORT      = 2'd3
    } status_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } entry_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] v;
        v = {8'h00, crc[7:0] ^ b};
        for (int i = 0; i < 8; i++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return {8'h00, crc[15:8]} ^ v;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/sfrx_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfrx_front
// Line byte classifier: flag detection and unstuffing, pushes frame events.
// ----------------------------------------------------------------------------
module sfrx_front
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [7:0]        in_byte,
    output logic                   push,
    output sfrx_pkg::entry_t       push_entry
);

    logic in_frame_reg, in_frame_next;
    logic esc_reg, esc_next;

    always_comb
    begin
        in_frame_next   = in_frame_reg;
        esc_next        = esc_reg;
        push            = 1'b0;
        push_entry.kind = sfrx_pkg::KIND_DATA;
        push_entry.data = in_byte;
        if (in_valid)
        begin
            priority if (!in_frame_reg)
            begin
                if (in_byte == sfrx_pkg::FLAG_OPEN)
                begin
                    in_frame_next   = 1'b1;
                    esc_next        = 1'b0;
                    push            = 1'b1;
                    push_entry.kind = sfrx_pkg::KIND_OPEN;
                end
            end
            else if (esc_reg)
            begin
                esc_next        = 1'b0;
                push            = 1'b1;
                push_entry.data = in_byte ^ sfrx_pkg::ESC_XOR;
            end
            else if (in_byte == sfrx_pkg::ESC_BYTE)
            begin
                esc_next = 1'b1;
            end
            else if (in_byte == sfrx_pkg::FLAG_OPEN)
            begin
                push            = 1'b1;
                push_entry.kind = sfrx_pkg::KIND_OPEN;
            end
            else if (in_byte == sfrx_pkg::FLAG_CLOSE)
            begin
                in_frame_next   = 1'b0;
                push            = 1'b1;
                push_entry.kind = sfrx_pkg::KIND_CLOSE;
            end
            else
            begin
                push = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            esc_reg      <= 1'b0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            esc_reg      <= esc_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/sfrx_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfrx_queue
// Short FIFO of frame events between the classifier and the frame engine.
// ----------------------------------------------------------------------------
module sfrx_queue
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire sfrx_pkg::entry_t  push_entry,
    output logic                   not_full,
    input  wire logic              pop,
    output logic                   not_empty,
    output sfrx_pkg::entry_t       head
);

    localparam int unsigned AW    = sfrx_pkg::QUEUE_ADDR_WIDTH;
    localparam int unsigned DEPTH = 1 << AW;

    sfrx_pkg::entry_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg, count_next;

    assign not_full  = (count_reg != (AW+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (AW+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/sfrx_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfrx_back
// Frame engine: CRC, byte count, header capture, FCS holdback, frame status.
// ----------------------------------------------------------------------------
module sfrx_back
#(
    parameter int unsigned COUNT_WIDTH = sfrx_pkg::COUNT_WIDTH_DEFAULT
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [sfrx_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [7:0]                          cfg_data,
    input  wire logic                                avail,
    input  wire sfrx_pkg::entry_t                    head,
    output logic                                     pop,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [7:0]                               out_payload,
    output logic                                     out_end,
    output logic [1:0]                               out_status,
    output logic [15:0]                              out_length
);

    logic [7:0] protocol_id_reg, message_type_reg;

    logic [15:0]            crc_reg, crc_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [7:0]             header_reg [4];
    logic [7:0]             hold_reg [2];

    logic                 valid_reg, valid_next;
    logic                 emit;
    logic [7:0]           payload_reg, payload_next;
    logic                 end_reg, end_next;
    sfrx_pkg::status_t    status_reg, status_next;
    logic [15:0]          length_reg;

    logic is_data, is_open, is_close;

    assign pop      = avail && (!valid_reg || out_ready);
    assign is_data  = pop && (head.kind == sfrx_pkg::KIND_DATA);
    assign is_open  = pop && (head.kind == sfrx_pkg::KIND_OPEN);
    assign is_close = pop && (head.kind == sfrx_pkg::KIND_CLOSE);

    always_comb
    begin
        crc_next     = crc_reg;
        count_next   = count_reg;
        emit         = 1'b0;
        payload_next = hold_reg[0];
        end_next     = 1'b0;
        status_next  = sfrx_pkg::ST_GOOD;
        if (pop)
        begin
            unique case (head.kind)
                sfrx_pkg::KIND_DATA:
                begin
                    crc_next = sfrx_pkg::crc_byte(crc_reg, head.data);
                    if (count_reg != '1)
                    begin
                        count_next = count_reg + COUNT_WIDTH'(1);
                    end
                    emit = (count_reg >= COUNT_WIDTH'(6));
                end
                sfrx_pkg::KIND_CLOSE:
                begin
                    crc_next     = sfrx_pkg::CRC_INIT;
                    count_next   = '0;
                    emit         = 1'b1;
                    payload_next = 8'h00;
                    end_next     = 1'b1;
                    priority if (count_reg < COUNT_WIDTH'(6))
                        status_next = sfrx_pkg::ST_SHORT;
                    else if (crc_reg != sfrx_pkg::CRC_GOOD)
                        status_next = sfrx_pkg::ST_BAD_FCS;
                    else if (header_reg[0] != protocol_id_reg ||
                             header_reg[1] != message_type_reg)
                        status_next = sfrx_pkg::ST_BAD_HEADER;
                    else
                        status_next = sfrx_pkg::ST_GOOD;
                end
                default:
                begin
                    crc_next   = sfrx_pkg::CRC_INIT;
                    count_next = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (out_ready)
        begin
            valid_next = 1'b0;
        end
        if (emit)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            protocol_id_reg  <= sfrx_pkg::PROTOCOL_ID_RESET;
            message_type_reg <= sfrx_pkg::MESSAGE_TYPE_RESET;
            crc_reg          <= sfrx_pkg::CRC_INIT;
            count_reg        <= '0;
            valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_write && cfg_index == sfrx_pkg::REG_PROTOCOL_ID)
            begin
                protocol_id_reg <= cfg_data;
            end
            if (cfg_write && cfg_index == sfrx_pkg::REG_MESSAGE_TYPE)
            begin
                message_type_reg <= cfg_data;
            end
            crc_reg   <= crc_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    // header reads as zero until captured, so clear it on every frame boundary
    always_ff @(posedge clk)
    begin
        if (is_open || is_close)
        begin
            for (int i = 0; i < 4; i++)
            begin
                header_reg[i] <= 8'h00;
            end
        end
        else if (is_data && count_reg < COUNT_WIDTH'(4))
        begin
            header_reg[count_reg[1:0]] <= head.data;
        end
        if (is_data)
        begin
            hold_reg[0] <= hold_reg[1];
            hold_reg[1] <= head.data;
        end
        if (emit)
        begin
            payload_reg <= payload_next;
            end_reg     <= end_next;
            status_reg  <= status_next;
            length_reg  <= {header_reg[2], header_reg[3]};
        end
    end

    assign out_valid   = valid_reg;
    assign out_payload = payload_reg;
    assign out_end     = end_reg;
    assign out_status  = status_reg;
    assign out_length  = length_reg;

endmodule
`default_nettype wire

// ===== hdl/serial_frame_receiver_crc16_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// serial_frame_receiver_crc16_top
// Byte-stuffed frame receiver with CRC-16 FCS check and header capture.
// Throughput: one line byte per cycle while the output side takes results.
// Pipeline: classifier into the event queue, frame engine into the output register.
// Reset: frame and queue state cleared, registers back to 0x11 and 0x01.
// ----------------------------------------------------------------------------
module serial_frame_receiver_crc16_top
#(
    parameter int unsigned COUNT_WIDTH = sfrx_pkg::COUNT_WIDTH_DEFAULT
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [7:0]                           s_tdata,   // [7:0] rx_byte
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // [7:0] payload_byte, [9:8] frame_status, [25:10] header_length, rest 0
    output logic [31:0]                               m_tdata,
    output logic                                      m_tlast,   // frame_end
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [sfrx_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [7:0]                           cfg_data
);

    logic             push, not_full, pop, not_empty;
    sfrx_pkg::entry_t push_entry, head;
    logic [7:0]       payload;
    logic [1:0]       status;
    logic [15:0]      length;

    assign s_tready  = not_full;
    assign cfg_ready = 1'b1;

    sfrx_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid && not_full),
        .in_byte    (s_tdata),
        .push       (push),
        .push_entry (push_entry)
    );

    sfrx_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .not_full   (not_full),
        .pop        (pop),
        .not_empty  (not_empty),
        .head       (head)
    );

    sfrx_back
    #(
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .avail       (not_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_payload (payload),
        .out_end     (m_tlast),
        .out_status  (status),
        .out_length  (length)
    );

    assign m_tdata = {6'b000000, length, status, payload};

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the byte-stuffed frame receiver. Line bytes are streamed in
// bursts; a local deframer and FCS model predicts every payload and status
// transfer, and a monitor compares each output transfer field by field.
// Directed frames cover stuffing, flags, short frames and status priority.
// Random frames, noise and broken frames follow. Config changes happen only
// while the receiver is idle.
// ----------------------------------------------------------------------------
module tb_top;

    // narrow counter so saturation is reached within short frames
    localparam int unsigned CNT_W         = 4;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned LINE_TARGET   = 400;

    typedef struct {
        logic [7:0]        payload;
        logic              last;
        sfrx_pkg::status_t status;
        logic [15:0]       hlen;
    } rx_result_t;

    logic                                 clk       = 1'b0;
    logic                                 rst_n     = 1'b0;
    logic                                 s_tvalid  = 1'b0;
    logic                                 s_tready;
    logic [7:0]                           s_tdata   = 8'h00;
    logic                                 m_tvalid;
    logic                                 m_tready  = 1'b0;
    logic [31:0]                          m_tdata;
    logic                                 m_tlast;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic [sfrx_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = sfrx_pkg::REG_PROTOCOL_ID;
    logic [7:0]                           cfg_data  = 8'h00;

    serial_frame_receiver_crc16_top #(
        .COUNT_WIDTH(CNT_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // deframer model state
    logic        fr_open = 1'b0;
    logic        fr_esc;
    logic [15:0] fr_crc;
    int unsigned fr_cnt;
    logic [7:0]  fr_hold [2];
    logic [7:0]  fr_hdr  [4];
    logic [7:0]  want_proto = sfrx_pkg::PROTOCOL_ID_RESET;
    logic [7:0]  want_type  = sfrx_pkg::MESSAGE_TYPE_RESET;

    rx_result_t  result_q [$];
    rx_result_t  chk_exp;
    int          err_cnt = 0;

    logic [7:0]  line_q [$];
    logic [7:0]  body_q [$];
    logic [7:0]  pay_q  [$];

    int          tx_burst    = 0;
    bit          tx_free     = 1'b0;
    bit          rx_free     = 1'b0;
    bit          rx_hold_req = 1'b0;
    int          line_sent   = 0;

    function automatic logic [15:0] fcs16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            if (c[0] ^ b[i])
                c = (c >> 1) ^ sfrx_pkg::CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    task automatic model_frame_clear();
        fr_esc  = 1'b0;
        fr_crc  = sfrx_pkg::CRC_INIT;
        fr_cnt  = 0;
        for (int i = 0; i < 2; i++)
            fr_hold[i] = 8'h00;
        for (int i = 0; i < 4; i++)
            fr_hdr[i] = 8'h00;
    endtask

    task automatic predict_byte(input logic [7:0] raw);
        logic [7:0]  b;
        rx_result_t  r;
        int unsigned n;
        b = raw;
        if (!fr_open)
        begin
            if (b == sfrx_pkg::FLAG_OPEN)
            begin
                fr_open = 1'b1;
                model_frame_clear();
            end
            return;
        end
        if (fr_esc)
        begin
            fr_esc = 1'b0;
            b      = b ^ sfrx_pkg::ESC_XOR;
        end
        else if (b == sfrx_pkg::ESC_BYTE)
        begin
            fr_esc = 1'b1;
            return;
        end
        else if (b == sfrx_pkg::FLAG_OPEN)
        begin
            model_frame_clear();
            return;
        end
        else if (b == sfrx_pkg::FLAG_CLOSE)
        begin
            r.payload = 8'h00;
            r.last    = 1'b1;
            r.hlen    = {fr_hdr[2], fr_hdr[3]};
            if (fr_cnt < 6)
                r.status = sfrx_pkg::ST_SHORT;
            else if (fr_crc != sfrx_pkg::CRC_GOOD)
                r.status = sfrx_pkg::ST_BAD_FCS;
            else if (fr_hdr[0] != want_proto || fr_hdr[1] != want_type)
                r.status = sfrx_pkg::ST_BAD_HEADER;
            else
                r.status = sfrx_pkg::ST_GOOD;
            result_q.insert(result_q.size(), r);
            fr_open = 1'b0;
            model_frame_clear();
            return;
        end
        n      = fr_cnt;
        fr_crc = fcs16_step(fr_crc, b);
        if (n < 4)
            fr_hdr[n] = b;
        if (n >= 6)
        begin
            r.payload = fr_hold[0];
            r.last    = 1'b0;
            r.status  = sfrx_pkg::ST_GOOD;
            r.hlen    = {fr_hdr[2], fr_hdr[3]};
            result_q.insert(result_q.size(), r);
        end
        fr_hold[0] = fr_hold[1];
        fr_hold[1] = b;
        if (n < (1 << CNT_W) - 1)
            fr_cnt = n + 1;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (result_q.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none, got tdata=%h tlast=%b",
                         $time, m_tdata, m_tlast);
                err_cnt++;
            end
            else
            begin
                chk_exp = result_q.pop_front();
                if (m_tdata[7:0] !== chk_exp.payload)
                begin
                    $display("%0t: payload_byte expected %h got %h",
                             $time, chk_exp.payload, m_tdata[7:0]);
                    err_cnt++;
                end
                if (m_tlast !== chk_exp.last)
                begin
                    $display("%0t: frame_end expected %b got %b", $time, chk_exp.last, m_tlast);
                    err_cnt++;
                end
                if (m_tdata[9:8] !== chk_exp.status)
                begin
                    $display("%0t: frame_status expected %0d got %0d",
                             $time, chk_exp.status, m_tdata[9:8]);
                    err_cnt++;
                end
                if (m_tdata[25:10] !== chk_exp.hlen)
                begin
                    $display("%0t: header_length expected %h got %h",
                             $time, chk_exp.hlen, m_tdata[25:10]);
                    err_cnt++;
                end
                if (m_tdata[31:26] !== 6'd0)
                begin
                    $display("%0t: tdata padding expected 00 got %h", $time, m_tdata[31:26]);
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin : rx_side
        int hold_left;
        int run_left;
        bit run_on;
        hold_left = 0;
        run_left  = 0;
        run_on    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (rx_free)
                m_tready <= 1'b1;
            else
            begin
                if (run_left == 0)
                begin
                    run_on   = !run_on;
                    run_left = run_on ? $urandom_range(1, 12) : $urandom_range(1, 6);
                end
                run_left--;
                m_tready <= run_on;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (tx_burst == 0)
        begin
            gap = tx_free ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            tx_burst = $urandom_range(1, 16);
        end
        tx_burst--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_byte(b);
    endtask

    task automatic send_line();
        line_sent += line_q.size();
        for (int i = 0; i < line_q.size(); i++)
            send_byte(line_q[i]);
        line_q.delete();
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        tx_burst = 0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [sfrx_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [7:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == sfrx_pkg::REG_PROTOCOL_ID)
            want_proto = val;
        else
            want_type = val;
    endtask

    task automatic push_stuffed(input logic [7:0] b, input bit esc_all);
        if (esc_all || b == sfrx_pkg::FLAG_OPEN || b == sfrx_pkg::FLAG_CLOSE
            || b == sfrx_pkg::ESC_BYTE || $urandom_range(0, 15) == 0)
        begin
            line_q.insert(line_q.size(), sfrx_pkg::ESC_BYTE);
            line_q.insert(line_q.size(), b ^ sfrx_pkg::ESC_XOR);
        end
        else
            line_q.insert(line_q.size(), b);
    endtask

    // header, pay_q contents, npay random bytes, FCS low byte first
    task automatic build_frame(input logic [7:0] proto, input logic [7:0] mtype,
                               input logic [15:0] len, input int npay,
                               input bit corrupt, input bit esc_all);
        logic [15:0] crc;
        logic [15:0] fcs;
        int          k;
        body_q.delete();
        body_q.insert(body_q.size(), proto);
        body_q.insert(body_q.size(), mtype);
        body_q.insert(body_q.size(), len[15:8]);
        body_q.insert(body_q.size(), len[7:0]);
        for (int i = 0; i < pay_q.size(); i++)
            body_q.insert(body_q.size(), pay_q[i]);
        pay_q.delete();
        for (int i = 0; i < npay; i++)
            body_q.insert(body_q.size(), 8'($urandom_range(0, 255)));
        crc = sfrx_pkg::CRC_INIT;
        for (int i = 0; i < body_q.size(); i++)
            crc = fcs16_step(crc, body_q[i]);
        fcs = ~crc;
        body_q.insert(body_q.size(), fcs[7:0]);
        body_q.insert(body_q.size(), fcs[15:8]);
        if (corrupt)
        begin
            k = $urandom_range(0, body_q.size() - 1);
            body_q[k] = body_q[k] ^ 8'(1 << $urandom_range(0, 7));
        end
        line_q.insert(line_q.size(), sfrx_pkg::FLAG_OPEN);
        for (int i = 0; i < body_q.size(); i++)
            push_stuffed(body_q[i], esc_all);
        line_q.insert(line_q.size(), sfrx_pkg::FLAG_CLOSE);
    endtask

    task automatic test_basic();
        build_frame(sfrx_pkg::PROTOCOL_ID_RESET, sfrx_pkg::MESSAGE_TYPE_RESET,
                    16'h0000, 0, 1'b0, 1'b0);
        pay_q.insert(pay_q.size(), 8'h00);
        pay_q.insert(pay_q.size(), 8'hFF);
        build_frame(sfrx_pkg::PROTOCOL_ID_RESET, sfrx_pkg::MESSAGE_TYPE_RESET,
                    16'hFFFF, 0, 1'b0, 1'b0);
        send_line();
    endtask

    task automatic test_stuffing();
        pay_q = '{sfrx_pkg::FLAG_OPEN, sfrx_pkg::FLAG_CLOSE, sfrx_pkg::ESC_BYTE,
                  8'hE0, 8'hE1, 8'h5D};
        build_frame(sfrx_pkg::PROTOCOL_ID_RESET, sfrx_pkg::MESSAGE_TYPE_RESET,
                    16'h0102, 0, 1'b0, 1'b1);
        pay_q = '{sfrx_pkg::FLAG_OPEN, sfrx_pkg::FLAG_CLOSE, sfrx_pkg::ESC_BYTE,
                  8'hE0, 8'hE1, 8'h5D};
        build_frame(sfrx_pkg::PROTOCOL_ID_RESET, sfrx_pkg::MESSAGE_TYPE_RESET,
                    16'h8001, 0, 1'b0, 1'b0);
        send_line();
    endtask

    task automatic test_outside_bytes();
        line_q = '{sfrx_pkg::FLAG_CLOSE, sfrx_pkg::ESC_BYTE, 8'h00, 8'hFF, 8'h41};
        build_frame(sfrx_pkg::PROTOCOL_ID_RESET, sfrx_pkg::MESSAGE_TYPE_RESET,
                    16'h0003, 3, 1'b0, 1'b0);
        send_line();
    endtask

    task automatic test_reopen();
        line_q = '{sfrx_pkg::FLAG_OPEN, 8'h11, 8'h01, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66};
        build_frame(sfrx_pkg::PROTOCOL_ID_RESET, sfrx_pkg::MESSAGE_TYPE_RESET,
                    16'h0204, 2, 1'b0, 1'b0);
        send_line();
    endtask

    task automatic test_short_frames();
        line_q = '{sfrx_pkg::FLAG_OPEN, sfrx_pkg::FLAG_CLOSE,
                   sfrx_pkg::FLAG_OPEN, 8'hAB, sfrx_pkg::FLAG_CLOSE,
                   sfrx_pkg::FLAG_OPEN, 8'h11, 8'h01, 8'h12, sfrx_pkg::FLAG_CLOSE,
                   sfrx_pkg::FLAG_OPEN, 8'h22, 8'h02, 8'h12, 8'h34, 8'h56,
                   sfrx_pkg::FLAG_CLOSE,
                   sfrx_pkg::FLAG_OPEN, sfrx_pkg::ESC_BYTE, sfrx_pkg::FLAG_CLOSE,
                   sfrx_pkg::FLAG_CLOSE};
        send_line();
    endtask

    task automatic test_status_priority();
        build_frame(sfrx_pkg::PROTOCOL_ID_RESET, sfrx_pkg::MESSAGE_TYPE_RESET,
                    16'h0010, 4, 1'b1, 1'b0);
        build_frame(8'h12, sfrx_pkg::MESSAGE_TYPE_RESET, 16'h0011, 2, 1'b0, 1'b0);
        build_frame(sfrx_pkg::PROTOCOL_ID_RESET, 8'h02, 16'h0012, 1, 1'b0, 1'b0);
        build_frame(8'h12, 8'h02, 16'h0013, 3, 1'b1, 1'b0);
        send_line();
    endtask

    task automatic test_count_saturation();
        build_frame(sfrx_pkg::PROTOCOL_ID_RESET, sfrx_pkg::MESSAGE_TYPE_RESET,
                    16'h0018, 24, 1'b0, 1'b0);
        build_frame(sfrx_pkg::PROTOCOL_ID_RESET, 8'h07, 16'h0014, 20, 1'b0, 1'b0);
        send_line();
    endtask

    task automatic test_registers();
        write_reg(sfrx_pkg::REG_PROTOCOL_ID, 8'h00);
        write_reg(sfrx_pkg::REG_MESSAGE_TYPE, 8'h00);
        build_frame(8'h00, 8'h00, 16'h0001, 1, 1'b0, 1'b0);
        build_frame(sfrx_pkg::PROTOCOL_ID_RESET, sfrx_pkg::MESSAGE_TYPE_RESET,
                    16'h0001, 1, 1'b0, 1'b0);
        send_line();
        write_reg(sfrx_pkg::REG_PROTOCOL_ID, 8'hFF);
        write_reg(sfrx_pkg::REG_MESSAGE_TYPE, 8'hFF);
        build_frame(8'hFF, 8'hFF, 16'hFF00, 2, 1'b0, 1'b0);
        build_frame(8'hFF, 8'h00, 16'h00FF, 2, 1'b0, 1'b0);
        send_line();
        write_reg(sfrx_pkg::REG_PROTOCOL_ID, sfrx_pkg::PROTOCOL_ID_RESET);
        write_reg(sfrx_pkg::REG_MESSAGE_TYPE, sfrx_pkg::MESSAGE_TYPE_RESET);
    endtask

    task automatic test_backpressure();
        wait_idle();
        tx_free     = 1'b1;
        rx_hold_req = 1'b1;
        build_frame(want_proto, want_type, 16'h0028, 40, 1'b0, 1'b0);
        send_line();
        tx_free = 1'b0;
        wait_idle();
    endtask

    task automatic test_random();
        int          pick;
        int          npay;
        int          cut;
        logic [7:0]  proto;
        logic [7:0]  mtype;
        while (line_sent < LINE_TARGET)
        begin
            if ($urandom_range(0, 9) == 0)
                tx_free = !tx_free;
            if ($urandom_range(0, 9) == 0)
                rx_free = !rx_free;
            if ($urandom_range(0, 11) == 0)
            begin
                write_reg(sfrx_pkg::REG_PROTOCOL_ID, 8'($urandom_range(0, 255)));
                write_reg(sfrx_pkg::REG_MESSAGE_TYPE, 8'($urandom_range(0, 255)));
            end
            else if ($urandom_range(0, 11) == 0)
                wait_idle();
            pick  = $urandom_range(0, 99);
            npay  = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 30) : $urandom_range(0, 10);
            proto = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : want_proto;
            mtype = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : want_type;
            if (pick < 60)
                build_frame(proto, mtype, 16'($urandom), npay, 1'b0, 1'b0);
            else if (pick < 70)
                build_frame(proto, mtype, 16'($urandom), npay, 1'b1, 1'b0);
            else if (pick < 80)
            begin
                // noise between frames
                repeat ($urandom_range(1, 6))
                    line_q.insert(line_q.size(), 8'($urandom_range(0, 255)));
                line_sent -= line_q.size();
            end
            else if (pick < 90)
            begin
                // frame cut off; the next opening flag discards it
                build_frame(proto, mtype, 16'($urandom), npay, 1'b0, 1'b0);
                cut = $urandom_range(1, line_q.size() - 1);
                repeat (cut)
                    line_q.delete(line_q.size() - 1);
            end
            else
            begin
                line_q.insert(line_q.size(), sfrx_pkg::FLAG_OPEN);
                repeat ($urandom_range(1, 12))
                begin
                    if ($urandom_range(0, 3) == 0)
                        line_q.insert(line_q.size(), sfrx_pkg::ESC_BYTE);
                    else
                        line_q.insert(line_q.size(), 8'($urandom_range(0, 255)));
                end
                line_q.insert(line_q.size(), sfrx_pkg::FLAG_CLOSE);
            end
            send_line();
        end
        tx_free = 1'b0;
        rx_free = 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic();
        test_stuffing();
        test_outside_bytes();
        test_reopen();
        test_short_frames();
        test_status_priority();
        test_count_saturation();
        test_registers();
        test_backpressure();
        test_random();
        wait_idle();
        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
